/* src/multichannel_one_pole_rc_filter_defines.svh */
// Assertion macros shared by the RC filter checker
`ifndef MULTICHANNEL_ONE_POLE_RC_FILTER_DEFINES_SVH
`define MULTICHANNEL_ONE_POLE_RC_FILTER_DEFINES_SVH

// same-cycle implication
`define RCF_ASSERT_IMPL(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RCF_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/rcf_pkg.sv */
// Shared constants, types and helpers of the multichannel RC filter
package rcf_pkg;

	localparam int SAMPLE_W = 32;
	localparam int CHAN_W = 3;
	localparam int ALPHA_W = 17;
	localparam int ALPHA_FRAC = 16;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
	localparam logic [ALPHA_W-1:0] ALPHA_HALF = ALPHA_W'(32768);
	localparam int SBYTES_W = 3;
	localparam logic [SBYTES_W-1:0] SBYTES_RESET = SBYTES_W'(2);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DW = ALPHA_W;

	localparam int DEF_MAX_CHANNELS = 8;
	localparam int DEF_FRAC_BITS = 16;
	localparam int DEF_STATE_DW = 34 + DEF_FRAC_BITS + SAMPLE_W;

	// stages s1..s5 plus the output register
	localparam int PIPE_DEPTH = 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_MODE  = 2'd0,
		REG_ALPHA_Q16    = 2'd1,
		REG_SAMPLE_BYTES = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		MODE_LOWPASS  = 1'b0,
		MODE_HIGHPASS = 1'b1
	} filter_mode_t;

	typedef enum logic [1:0] {
		WID_8  = 2'd0,
		WID_16 = 2'd1,
		WID_24 = 2'd2,
		WID_32 = 2'd3
	} samp_w_t;

	function automatic samp_w_t decode_width(input logic [SBYTES_W-1:0] sb);
		samp_w_t w;
		case (sb)
			3'd0, 3'd1: w = WID_8;
			3'd2:       w = WID_16;
			3'd3:       w = WID_24;
			default:    w = WID_32;
		endcase
		return w;
	endfunction

endpackage

/* src/rcf_ifs.sv */
// Valid/ready channel interfaces of the RC filter: samples in, samples out, config writes
interface rcf_in_if import rcf_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic [CHAN_W-1:0]          chan_index;
	logic                       first_frame;

	modport source(output valid, sample_in, chan_index, first_frame, input ready);
	modport sink(input valid, sample_in, chan_index, first_frame, output ready);
endinterface

interface rcf_out_if import rcf_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic [CHAN_W-1:0]          chan_out;

	modport source(output valid, sample_out, chan_out, input ready);
	modport sink(input valid, sample_out, chan_out, output ready);
endinterface

interface rcf_cfg_if import rcf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DW-1:0]    wdata;

	modport source(output valid, index, wdata, input ready);
	modport sink(input valid, index, wdata, output ready);
endinterface

/* src/rcf_state_ram.sv */
// Per-channel filter state memory: one read and one write port, registered read, written flags
module rcf_state_ram import rcf_pkg::*; #(
	parameter int DEPTH = DEF_MAX_CHANNELS,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int DW = DEF_STATE_DW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	output logic          rd_hit,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0]    mem_q [DEPTH];
	logic [DW-1:0]    rd_data_q;
	logic [DEPTH-1:0] written_q;
	logic             rd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// entries never written return rd_hit low, and the filter reads them as zero state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_hit_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;
	assign rd_hit  = rd_hit_q;

endmodule

/* src/multichannel_one_pole_rc_filter.sv */
// Multichannel one-pole RC filter (low-pass / high-pass) over interleaved PCM samples.
// Takes one sample beat per clock unless the output stalls or the beat's channel is busy;
// each result passes stages s1..s5 and the output register. Per-channel state (last output,
// last input) lives in a single memory that is read when a beat is taken and written back
// from stage s4, with the write-back forwarded to a beat read in the same cycle. A beat
// whose channel matches one of the beats in the first three stages is held, so a beat
// of one channel waits until the last beat of that channel reaches s4; that read-modify-write
// loop through the alpha multiplier sets the per-channel rate. State reads as zero after reset
// without any clearing pass. A first-frame beat seeds its channel and passes through unchanged.
module multichannel_one_pole_rc_filter import rcf_pkg::*; #(
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input logic       clk,
	input logic       arst_n,
	rcf_cfg_if.sink   cfg,
	rcf_in_if.sink    din,
	rcf_out_if.source dout
);

	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int RED_W = (CH_W + 1 > CHAN_W) ? CH_W + 1 : CHAN_W;
	localparam int CHAN_MAX = (1 << CHAN_W) - 1;
	localparam int ST_W = 34 + FRAC_BITS;
	localparam int VW = ST_W + 1;
	localparam int MW = ST_W;
	localparam int HW = MW - ALPHA_FRAC;
	localparam int PHW = HW + ALPHA_W;
	localparam int PLW = ALPHA_FRAC + ALPHA_W;
	localparam int DW = ST_W + SAMPLE_W;
	localparam int QW = ST_W + 1 - FRAC_BITS;
	localparam logic [ST_W:0] HALF_LSB = (ST_W + 1)'(1) << (FRAC_BITS - 1);
	localparam logic [QW-1:0] U8_MIN = '0;
	localparam logic [QW-1:0] U8_MAX = {{(QW - 8){1'b0}}, 8'hFF};
	localparam logic [QW-1:0] S16_MIN = {{(QW - 15){1'b1}}, 15'd0};
	localparam logic [QW-1:0] S16_MAX = {{(QW - 15){1'b0}}, {15{1'b1}}};
	localparam logic [QW-1:0] S24_MIN = {{(QW - 23){1'b1}}, 23'd0};
	localparam logic [QW-1:0] S24_MAX = {{(QW - 23){1'b0}}, {23{1'b1}}};
	localparam logic [QW-1:0] S32_MIN = {{(QW - 31){1'b1}}, 31'd0};
	localparam logic [QW-1:0] S32_MAX = {{(QW - 31){1'b0}}, {31{1'b1}}};

	function automatic logic [SAMPLE_W-1:0] sat(input logic signed [QW-1:0] q,
			input logic signed [QW-1:0] lo, input logic signed [QW-1:0] hi);
		logic signed [QW-1:0] r;
		if (q < lo) r = lo;
		else if (q > hi) r = hi;
		else r = q;
		return r[SAMPLE_W-1:0];
	endfunction

	// configuration
	filter_mode_t         mode_q;
	logic [ALPHA_W-1:0]   alpha_q;
	logic [SBYTES_W-1:0]  sbytes_q;
	samp_w_t              nb_c;
	logic [ALPHA_W-1:0]   alpha_c;

	// input side
	logic [RED_W-1:0]           red_c;
	logic [CH_W-1:0]            in_idx_c;
	logic signed [SAMPLE_W-1:0] x_c;
	logic                       haz_c;
	logic                       fwd_c;
	logic                       acc_c;
	logic                       rdy1_c, rdy2_c, rdy3_c, rdy4_c, rdy5_c, rdy_o_c;

	// memory
	logic [DW-1:0] rd_data;
	logic          rd_hit;
	logic [DW-1:0] wr_data_c;

	// s1
	logic                       vld_s1;
	logic signed [SAMPLE_W-1:0] x_s1;
	logic [CH_W-1:0]            idx_s1;
	logic [CHAN_W-1:0]          chan_s1;
	logic                       first_s1;
	logic                       fwd_s1;
	logic [DW-1:0]              fwd_data_s1;
	logic [DW-1:0]              st_c;
	logic [ST_W-1:0]            prev_o_c;
	logic [SAMPLE_W-1:0]        prev_i_c;
	logic [SAMPLE_W:0]          dx_c;
	logic [VW-1:0]              hp_c, lp_c, v_c, absv_c;

	// s2
	logic                       vld_s2;
	logic [MW-1:0]              mag_s2;
	logic                       neg_s2;
	logic [ST_W-1:0]            prev_s2;
	logic signed [SAMPLE_W-1:0] x_s2;
	logic                       first_s2;
	logic [CHAN_W-1:0]          chan_s2;
	logic [CH_W-1:0]            idx_s2;
	logic [PHW-1:0]             phi_c;
	logic [PLW-1:0]             plo_c;

	// s3
	logic                       vld_s3;
	logic [PHW-1:0]             phi_s3;
	logic [PLW-1:0]             plo_s3;
	logic                       neg_s3;
	logic [ST_W-1:0]            prev_s3;
	logic signed [SAMPLE_W-1:0] x_s3;
	logic                       first_s3;
	logic [CHAN_W-1:0]          chan_s3;
	logic [CH_W-1:0]            idx_s3;
	logic [PLW-1:0]             rnd_c;
	logic [PHW-1:0]             rsum_c;

	// s4
	logic                       vld_s4;
	logic [MW-1:0]              r_s4;
	logic                       neg_s4;
	logic [ST_W-1:0]            prev_s4;
	logic signed [SAMPLE_W-1:0] x_s4;
	logic                       first_s4;
	logic [CHAN_W-1:0]          chan_s4;
	logic [CH_W-1:0]            idx_s4;
	logic [VW-1:0]              rs_c;
	logic [VW:0]                ysum_c;
	logic [ST_W-1:0]            yclamp_c;
	logic [ST_W-1:0]            y4_c;

	// s5 and output
	logic                       vld_s5;
	logic [ST_W-1:0]            y_s5;
	logic [CHAN_W-1:0]          chan_s5;
	logic [ST_W:0]              t_c;
	logic signed [QW-1:0]       q_c;
	logic [SAMPLE_W-1:0]        res_c;
	logic                       out_vld_q;
	logic [SAMPLE_W-1:0]        sample_out_q;
	logic [CHAN_W-1:0]          chan_out_q;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_LOWPASS;
			alpha_q  <= ALPHA_ONE;
			sbytes_q <= SBYTES_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_FILTER_MODE:  mode_q <= filter_mode_t'(cfg.wdata[0]);
				REG_ALPHA_Q16:    alpha_q <= cfg.wdata[ALPHA_W-1:0];
				REG_SAMPLE_BYTES: sbytes_q <= cfg.wdata[SBYTES_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;
	assign nb_c      = decode_width(sbytes_q);
	assign alpha_c   = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;

	// ---------------------------------------------------------------- input
	always_comb begin
		red_c = RED_W'(din.chan_index);
		for (int k = 0; k < CHAN_MAX; k++) begin
			if (red_c >= RED_W'(MAX_CHANNELS)) begin
				red_c = red_c - RED_W'(MAX_CHANNELS);
			end
		end
	end

	assign in_idx_c = red_c[CH_W-1:0];

	always_comb begin
		case (nb_c)
			WID_8:   x_c = {24'd0, din.sample_in[7:0]};
			WID_16:  x_c = {{16{din.sample_in[15]}}, din.sample_in[15:0]};
			WID_24:  x_c = {{8{din.sample_in[23]}}, din.sample_in[23:0]};
			default: x_c = din.sample_in;
		endcase
	end

	assign haz_c = (vld_s1 && idx_s1 == in_idx_c) || (vld_s2 && idx_s2 == in_idx_c) ||
		(vld_s3 && idx_s3 == in_idx_c);
	assign fwd_c = vld_s4 && idx_s4 == in_idx_c;

	assign rdy_o_c = !out_vld_q || dout.ready;
	assign rdy5_c  = !vld_s5 || rdy_o_c;
	assign rdy4_c  = !vld_s4 || rdy5_c;
	assign rdy3_c  = !vld_s3 || rdy4_c;
	assign rdy2_c  = !vld_s2 || rdy3_c;
	assign rdy1_c  = !vld_s1 || rdy2_c;

	assign din.ready = rdy1_c && !haz_c;
	assign acc_c     = din.valid && din.ready;

	// ---------------------------------------------------------------- state memory
	assign wr_data_c = {y4_c, x_s4};

	rcf_state_ram #(
		.DEPTH(MAX_CHANNELS),
		.AW(CH_W),
		.DW(DW)
	) u_ram (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(acc_c),
		.rd_addr(in_idx_c),
		.rd_data(rd_data),
		.rd_hit(rd_hit),
		.wr_en(vld_s4),
		.wr_addr(idx_s4),
		.wr_data(wr_data_c)
	);

	// ---------------------------------------------------------------- pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy1_c) vld_s1 <= acc_c;
			if (rdy2_c) vld_s2 <= vld_s1;
			if (rdy3_c) vld_s3 <= vld_s2;
			if (rdy4_c) vld_s4 <= vld_s3;
			if (rdy5_c) vld_s5 <= vld_s4;
			if (rdy_o_c) out_vld_q <= vld_s5;
		end
	end

	// ---------------------------------------------------------------- s1: form operand
	always_ff @(posedge clk) begin
		if (acc_c) begin
			x_s1        <= x_c;
			idx_s1      <= in_idx_c;
			chan_s1     <= din.chan_index;
			first_s1    <= din.first_frame;
			fwd_s1      <= fwd_c;
			fwd_data_s1 <= wr_data_c;
		end
	end

	always_comb begin
		if (fwd_s1) st_c = fwd_data_s1;
		else if (rd_hit) st_c = rd_data;
		else st_c = '0;
		prev_o_c = st_c[DW-1:SAMPLE_W];
		prev_i_c = st_c[SAMPLE_W-1:0];
		dx_c = {x_s1[SAMPLE_W-1], x_s1} - {prev_i_c[SAMPLE_W-1], prev_i_c};
		hp_c = {{(VW - ST_W){prev_o_c[ST_W-1]}}, prev_o_c} +
			{{(VW - SAMPLE_W - 1 - FRAC_BITS){dx_c[SAMPLE_W]}}, dx_c, {FRAC_BITS{1'b0}}};
		lp_c = {{(VW - SAMPLE_W - FRAC_BITS){x_s1[SAMPLE_W-1]}}, x_s1, {FRAC_BITS{1'b0}}} -
			{{(VW - ST_W){prev_o_c[ST_W-1]}}, prev_o_c};
		v_c = (mode_q == MODE_HIGHPASS) ? hp_c : lp_c;
		absv_c = v_c[VW-1] ? (VW'(0) - v_c) : v_c;
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && rdy2_c) begin
			mag_s2   <= absv_c[MW-1:0];
			neg_s2   <= v_c[VW-1];
			prev_s2  <= prev_o_c;
			x_s2     <= x_s1;
			first_s2 <= first_s1;
			chan_s2  <= chan_s1;
			idx_s2   <= idx_s1;
		end
	end

	// ---------------------------------------------------------------- s2: alpha multiply
	assign phi_c = mag_s2[MW-1:ALPHA_FRAC] * alpha_c;
	assign plo_c = mag_s2[ALPHA_FRAC-1:0] * alpha_c;

	always_ff @(posedge clk) begin
		if (vld_s2 && rdy3_c) begin
			phi_s3   <= phi_c;
			plo_s3   <= plo_c;
			neg_s3   <= neg_s2;
			prev_s3  <= prev_s2;
			x_s3     <= x_s2;
			first_s3 <= first_s2;
			chan_s3  <= chan_s2;
			idx_s3   <= idx_s2;
		end
	end

	// ---------------------------------------------------------------- s3: round product
	assign rnd_c  = plo_s3 + PLW'(ALPHA_HALF);
	assign rsum_c = phi_s3 + PHW'(rnd_c[PLW-1:ALPHA_FRAC]);

	always_ff @(posedge clk) begin
		if (vld_s3 && rdy4_c) begin
			r_s4     <= rsum_c[MW-1:0];
			neg_s4   <= neg_s3;
			prev_s4  <= prev_s3;
			x_s4     <= x_s3;
			first_s4 <= first_s3;
			chan_s4  <= chan_s3;
			idx_s4   <= idx_s3;
		end
	end

	// ---------------------------------------------------------------- s4: update, clamp, write back
	always_comb begin
		rs_c = neg_s4 ? (VW'(0) - {1'b0, r_s4}) : {1'b0, r_s4};
		if (mode_q == MODE_HIGHPASS) begin
			ysum_c = {rs_c[VW-1], rs_c};
		end else begin
			ysum_c = {{(VW + 1 - ST_W){prev_s4[ST_W-1]}}, prev_s4} + {rs_c[VW-1], rs_c};
		end
		if (ysum_c[VW:ST_W-1] == '0 || ysum_c[VW:ST_W-1] == '1) begin
			yclamp_c = ysum_c[ST_W-1:0];
		end else if (ysum_c[VW]) begin
			yclamp_c = {1'b1, {(ST_W - 1){1'b0}}};
		end else begin
			yclamp_c = {1'b0, {(ST_W - 1){1'b1}}};
		end
		if (first_s4) begin
			y4_c = {{(ST_W - SAMPLE_W - FRAC_BITS){x_s4[SAMPLE_W-1]}}, x_s4,
				{FRAC_BITS{1'b0}}};
		end else begin
			y4_c = yclamp_c;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s4 && rdy5_c) begin
			y_s5    <= y4_c;
			chan_s5 <= chan_s4;
		end
	end

	// ---------------------------------------------------------------- s5: round to sample, saturate
	always_comb begin
		t_c = {y_s5[ST_W-1], y_s5} + HALF_LSB;
		q_c = t_c[ST_W:FRAC_BITS];
		case (nb_c)
			WID_8:   res_c = sat(q_c, U8_MIN, U8_MAX);
			WID_16:  res_c = sat(q_c, S16_MIN, S16_MAX);
			WID_24:  res_c = sat(q_c, S24_MIN, S24_MAX);
			default: res_c = sat(q_c, S32_MIN, S32_MAX);
		endcase
	end

	always_ff @(posedge clk) begin
		if (vld_s5 && rdy_o_c) begin
			sample_out_q <= res_c;
			chan_out_q   <= chan_s5;
		end
	end

	assign dout.valid      = out_vld_q;
	assign dout.sample_out = sample_out_q;
	assign dout.chan_out   = chan_out_q;

endmodule

/* src/rcf_checker.sv */
// Port-level checker for the RC filter, bound to the top level
`include "multichannel_one_pole_rc_filter_defines.svh"

module rcf_checker import rcf_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 din_valid,
	input logic                 din_ready,
	input logic                 dout_valid,
	input logic                 dout_ready,
	input logic [SAMPLE_W-1:0]  dout_sample,
	input logic [CHAN_W-1:0]    dout_chan,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DW-1:0]    cfg_wdata
);

	logic [3:0]          pend_q;
	logic [SBYTES_W-1:0] sb_q;
	logic                in_beat;
	logic                out_beat;
	logic                narrow;

	assign in_beat  = din_valid && din_ready;
	assign out_beat = dout_valid && dout_ready;
	assign narrow   = decode_width(sb_q) == WID_8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			sb_q   <= SBYTES_RESET;
		end else begin
			pend_q <= pend_q + 4'(in_beat) - 4'(out_beat);
			if (cfg_valid && cfg_ready && cfg_index == REG_SAMPLE_BYTES) begin
				sb_q <= cfg_wdata[SBYTES_W-1:0];
			end
		end
	end

	`RCF_ASSERT_NEXT(a_out_hold, clk, arst_n, dout_valid && !dout_ready,
		dout_valid && $stable(dout_sample) && $stable(dout_chan), "output beat changed while stalled")
	`RCF_ASSERT_IMPL(a_no_extra, clk, arst_n, out_beat, pend_q != 4'd0,
		"output beat without a pending input beat")
	`RCF_ASSERT_IMPL(a_depth, clk, arst_n, 1'b1, pend_q <= 4'(PIPE_DEPTH),
		"more beats in flight than pipeline stages")
	`RCF_ASSERT_IMPL(a_u8_range, clk, arst_n, dout_valid && narrow,
		dout_sample[SAMPLE_W-1:8] == '0, "8-bit result outside 0..255")

endmodule

bind multichannel_one_pole_rc_filter rcf_checker u_rcf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.din_valid(din.valid),
	.din_ready(din.ready),
	.dout_valid(dout.valid),
	.dout_ready(dout.ready),
	.dout_sample(dout.sample_out),
	.dout_chan(dout.chan_out),
	.cfg_valid(cfg.valid),
	.cfg_ready(cfg.ready),
	.cfg_index(cfg.index),
	.cfg_wdata(cfg.wdata)
);
